/* rtl/core/deq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int WORD_W    = 32;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_LIST       = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP_OUT,
		S_LIST_OUT
	} state_t;

	typedef enum logic [2:0] {
		MOP_NONE,
		MOP_PUSH_FRONT,
		MOP_PUSH_BACK,
		MOP_POP_FRONT,
		MOP_POP_BACK,
		MOP_LIST_FIRST,
		MOP_LIST_NEXT
	} mem_op_t;

	// controller -> datapath
	typedef struct packed {
		mem_op_t mem_op;
		logic    out_load;
		logic    out_from_mem;
		status_t out_status;
		logic    out_last;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic full;
		logic out_free;
		logic list_final;
	} stat_t;

endpackage

`default_nettype wire

/* rtl/core/deq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [deq_pkg::OP_W-1:0]    operation,
	input  wire deq_pkg::stat_t              stat,
	output deq_pkg::cmd_t                    cmd
);

	deq_pkg::state_t state_q;
	deq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		in_stall         = 1'b1;
		cmd.mem_op       = deq_pkg::MOP_NONE;
		cmd.out_load     = 1'b0;
		cmd.out_from_mem = 1'b0;
		cmd.out_status   = deq_pkg::STAT_OK;
		cmd.out_last     = 1'b1;
		unique case (state_q)
			deq_pkg::S_IDLE: begin
				in_stall = !stat.out_free;
				if (in_valid && stat.out_free) begin
					unique case (operation)
						deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
							cmd.out_load = 1'b1;
							if (stat.full) begin
								cmd.out_status = deq_pkg::STAT_FULL;
							end else if (operation == deq_pkg::OP_PUSH_FRONT) begin
								cmd.mem_op = deq_pkg::MOP_PUSH_FRONT;
							end else begin
								cmd.mem_op = deq_pkg::MOP_PUSH_BACK;
							end
						end
						deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
							if (stat.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = deq_pkg::STAT_EMPTY;
							end else begin
								cmd.mem_op = (operation == deq_pkg::OP_POP_FRONT) ?
									deq_pkg::MOP_POP_FRONT : deq_pkg::MOP_POP_BACK;
								state_d = deq_pkg::S_POP_OUT;
							end
						end
						deq_pkg::OP_LIST: begin
							if (stat.empty) begin
								cmd.out_load   = 1'b1;
								cmd.out_status = deq_pkg::STAT_EMPTY;
							end else begin
								cmd.mem_op = deq_pkg::MOP_LIST_FIRST;
								state_d    = deq_pkg::S_LIST_OUT;
							end
						end
						default: begin
							// unused codes: drop silently
						end
					endcase
				end
			end
			deq_pkg::S_POP_OUT: begin
				if (stat.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_from_mem = 1'b1;
					state_d          = deq_pkg::S_IDLE;
				end
			end
			deq_pkg::S_LIST_OUT: begin
				if (stat.out_free) begin
					cmd.out_load     = 1'b1;
					cmd.out_from_mem = 1'b1;
					cmd.out_last     = stat.list_final;
					if (stat.list_final) begin
						state_d = deq_pkg::S_IDLE;
					end else begin
						cmd.mem_op = deq_pkg::MOP_LIST_NEXT;
					end
				end
			end
			default: begin
				state_d = deq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/core/deq_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module deq_dp #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic signed [deq_pkg::WORD_W-1:0] value,
	input  wire deq_pkg::cmd_t                    cmd,
	output deq_pkg::stat_t                        stat,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output deq_pkg::status_t                      status,
	output logic signed [deq_pkg::WORD_W-1:0]     word,
	output logic                                  last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	logic [deq_pkg::WORD_W-1:0] mem [DEPTH];
	logic [deq_pkg::WORD_W-1:0] rd_data_q;

	logic [AW-1:0] front_q;
	logic [AW-1:0] tail_q;     // slot the next back push lands in
	logic [CW-1:0] count_q;
	logic [AW-1:0] walk_q;
	logic [CW-1:0] left_q;

	logic out_valid_q;
	deq_pkg::status_t status_q;
	logic [deq_pkg::WORD_W-1:0] word_q;
	logic last_q;

	logic [AW-1:0] front_inc, front_dec, tail_inc, tail_dec, walk_inc;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;

	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign tail_inc  = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
	assign tail_dec  = (tail_q == '0) ? LAST_IDX : tail_q - AW'(1);
	assign walk_inc  = (walk_q == LAST_IDX) ? '0 : walk_q + AW'(1);

	always_comb begin
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		wr_addr = tail_q;
		rd_addr = front_q;
		unique case (cmd.mem_op)
			deq_pkg::MOP_PUSH_FRONT: begin
				wr_en   = 1'b1;
				wr_addr = front_dec;
			end
			deq_pkg::MOP_PUSH_BACK: begin
				wr_en = 1'b1;
			end
			deq_pkg::MOP_POP_FRONT, deq_pkg::MOP_LIST_FIRST: begin
				rd_en = 1'b1;
			end
			deq_pkg::MOP_POP_BACK: begin
				rd_en   = 1'b1;
				rd_addr = tail_dec;
			end
			deq_pkg::MOP_LIST_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = walk_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			tail_q  <= '0;
			count_q <= '0;
			walk_q  <= '0;
			left_q  <= '0;
		end else begin
			unique case (cmd.mem_op)
				deq_pkg::MOP_PUSH_FRONT: begin
					front_q <= front_dec;
					count_q <= count_q + CW'(1);
				end
				deq_pkg::MOP_PUSH_BACK: begin
					tail_q  <= tail_inc;
					count_q <= count_q + CW'(1);
				end
				deq_pkg::MOP_POP_FRONT: begin
					front_q <= front_inc;
					count_q <= count_q - CW'(1);
				end
				deq_pkg::MOP_POP_BACK: begin
					tail_q  <= tail_dec;
					count_q <= count_q - CW'(1);
				end
				deq_pkg::MOP_LIST_FIRST: begin
					walk_q <= front_inc;
					left_q <= count_q;
				end
				deq_pkg::MOP_LIST_NEXT: begin
					walk_q <= walk_inc;
					left_q <= left_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status_q <= cmd.out_status;
			word_q   <= cmd.out_from_mem ? rd_data_q : '0;
			last_q   <= cmd.out_last;
		end
	end

	assign stat.empty      = (count_q == '0);
	assign stat.full       = (count_q == CW'(DEPTH));
	assign stat.out_free   = !out_valid_q || !out_stall;
	assign stat.list_final = (left_q == CW'(1));

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign word      = word_q;
	assign last      = last_q;

endmodule

`default_nettype wire

/* rtl/core/double_ended_queue_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   operation[2:0], value[31:0] signed
// out      source     out_valid/out_stall status[1:0], word[31:0] signed, last
//
// Push: the ring buffer is written at the transfer edge.
// Pop: the word passes through the registered memory read port and then the
//   output register, which a stalled output holds off. Listing: one memory
//   read per stored word, all through the single memory read port.
// Reset clears the pointers, the fill count and the output valid; the slots
//   themselves are not cleared. A stalled output holds and backs up the input.

module double_ended_queue_top #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [deq_pkg::OP_W-1:0]          operation,
	input  wire logic signed [deq_pkg::WORD_W-1:0] value,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [deq_pkg::STATUS_W-1:0]           status,
	output logic signed [deq_pkg::WORD_W-1:0]      word,
	output logic                                   last
);

	deq_pkg::cmd_t    cmd;
	deq_pkg::stat_t   stat;
	deq_pkg::status_t status_e;

	// Sequencer: decodes each transfer and walks pops and listings out.
	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Ring buffer, front/tail pointers, fill count, list walker, output register.
	deq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status_e),
		.word      (word),
		.last      (last)
	);

	assign status = status_e;

	// The queue can never be both empty and full.
	a_not_empty_and_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.empty && stat.full))
		else $error("queue flagged empty and full at once");

	// A push that fits answers OK on the very next cycle.
	a_push_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !stat.full &&
		 (operation == deq_pkg::OP_PUSH_FRONT || operation == deq_pkg::OP_PUSH_BACK))
		|=> (out_valid && status == deq_pkg::STAT_OK && last))
		else $error("push did not answer OK");

	// A listing of a non-empty queue holds off the next transfer.
	a_list_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !stat.empty && operation == deq_pkg::OP_LIST)
		|=> in_stall)
		else $error("input taken during a listing");

endmodule

`default_nettype wire
